// File: sv/u8vs_pkg.sv
package u8vs_pkg;

    // byte values used by the sequence checker
    localparam logic [7:0] BYTE_NUL      = 8'h00;
    localparam logic [7:0] ASCII_TOP     = 8'h80;
    localparam logic [7:0] LEAD2_LO      = 8'hC2;
    localparam logic [7:0] LEAD2_HI      = 8'hDF;
    localparam logic [7:0] LEAD3_LO      = 8'hE0;
    localparam logic [7:0] LEAD3_HI      = 8'hEF;
    localparam logic [7:0] LEAD_E0       = 8'hE0;
    localparam logic [7:0] LEAD_ED       = 8'hED;
    localparam logic [7:0] LEAD4_LO      = 8'hF0;
    localparam logic [7:0] LEAD4_HI      = 8'hF4;
    localparam logic [7:0] LEAD_F0       = 8'hF0;
    localparam logic [7:0] LEAD_F4       = 8'hF4;
    localparam logic [7:0] CONT_LO       = 8'h80;
    localparam logic [7:0] CONT_HI       = 8'hBF;
    localparam logic [7:0] AFTER_E0_LO   = 8'hA0;
    localparam logic [7:0] AFTER_ED_HI   = 8'h9F;
    localparam logic [7:0] AFTER_F0_LO   = 8'h90;
    localparam logic [7:0] AFTER_F4_HI   = 8'h8F;
    localparam logic [7:0] QMARK         = 8'h3F;

    localparam logic [2:0] SEQ_LEN2      = 3'd2;
    localparam logic [2:0] SEQ_LEN3      = 3'd3;
    localparam logic [2:0] SEQ_LEN4      = 3'd4;
    localparam logic [2:0] SEQ_NONE      = 3'd0;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one command: up to four result bytes released by one input byte
    typedef struct packed {
        logic [2:0]      n;      // number of results, 1..4
        logic [3:0][7:0] data;   // result bytes, entry 0 first
        logic            fin;    // last result is the end-of-string result
        logic            clean;  // clean flag carried by the end result
    } cmd_t;

    // queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: sv/u8vs_front.sv
module u8vs_front import u8vs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  q_stat_t    q_stat,
    output logic       push,
    output cmd_t       push_cmd
);

    logic            replace_reg;
    logic [2:0][7:0] held_reg;
    logic [2:0][7:0] held_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic [2:0]      exp_reg;
    logic [2:0]      exp_next;
    logic            clean_reg;
    logic            clean_next;

    logic            accept;
    logic [7:0]      lo;
    logic [7:0]      hi;
    logic            cont_ok;
    logic [2:0]      n_held;
    logic [2:0][7:0] src;
    logic            extra_valid;
    logic [7:0]      extra_byte;
    logic            clean_eff;
    logic [7:0]      c;

    assign c       = s_data_byte;
    assign s_ready = ~q_stat.full;
    assign accept  = s_valid & s_ready;

    // allowed range of a continuation byte
    always_comb begin
        lo = CONT_LO;
        hi = CONT_HI;
        if (count_reg == 2'd1) begin
            unique case (held_reg[0])
                LEAD_E0: lo = AFTER_E0_LO;
                LEAD_ED: hi = AFTER_ED_HI;
                LEAD_F0: lo = AFTER_F0_LO;
                LEAD_F4: hi = AFTER_F4_HI;
                default: ;
            endcase
        end
        cont_ok = (c >= lo) && (c <= hi);
    end

    always_comb begin
        held_next   = held_reg;
        count_next  = count_reg;
        exp_next    = exp_reg;
        clean_next  = clean_reg;
        n_held      = 3'd0;
        src         = held_reg;
        extra_valid = 1'b0;
        extra_byte  = BYTE_NUL;
        clean_eff   = clean_reg;
        push_cmd    = '0;

        if (count_reg != 2'd0 && cont_ok) begin
            if (({1'b0, count_reg} + 3'd1) >= exp_reg) begin
                // sequence complete: release it unchanged
                n_held      = {1'b0, count_reg};
                extra_valid = 1'b1;
                extra_byte  = c;
                count_next  = 2'd0;
                exp_next    = SEQ_NONE;
            end else begin
                held_next[count_reg] = c;
                count_next           = count_reg + 2'd1;
            end
        end else begin
            if (count_reg != 2'd0) begin
                // broken sequence: flush held bytes as bad
                n_held     = {1'b0, count_reg};
                if (replace_reg) begin
                    src = {3{QMARK}};
                end
                clean_eff  = 1'b0;
                clean_next = 1'b0;
                count_next = 2'd0;
                exp_next   = SEQ_NONE;
            end
            priority if (c == BYTE_NUL) begin
                extra_valid    = 1'b1;
                extra_byte     = BYTE_NUL;
                push_cmd.fin   = 1'b1;
                push_cmd.clean = clean_eff;
                clean_next     = 1'b1;
            end else if (c < ASCII_TOP) begin
                extra_valid = 1'b1;
                extra_byte  = c;
            end else if (c >= LEAD2_LO && c <= LEAD2_HI) begin
                held_next[0] = c;
                count_next   = 2'd1;
                exp_next     = SEQ_LEN2;
            end else if (c >= LEAD3_LO && c <= LEAD3_HI) begin
                held_next[0] = c;
                count_next   = 2'd1;
                exp_next     = SEQ_LEN3;
            end else if (c >= LEAD4_LO && c <= LEAD4_HI) begin
                held_next[0] = c;
                count_next   = 2'd1;
                exp_next     = SEQ_LEN4;
            end else begin
                extra_valid = 1'b1;
                extra_byte  = replace_reg ? QMARK : c;
                clean_next  = 1'b0;
            end
        end

        push_cmd.n = n_held + {2'b00, extra_valid};
        for (int i = 0; i < 3; i++) begin
            push_cmd.data[i] = (3'(i) < n_held) ? src[i] : extra_byte;
        end
        push_cmd.data[3] = extra_byte;
    end

    assign push = accept & (push_cmd.n != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            replace_reg <= 1'b1;
            count_reg   <= 2'd0;
            exp_reg     <= SEQ_NONE;
            clean_reg   <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                replace_reg <= cfg_wr_data;
            end
            if (accept) begin
                count_reg <= count_next;
                exp_reg   <= exp_next;
                clean_reg <= clean_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

endmodule

// File: sv/u8vs_queue.sv
module u8vs_queue import u8vs_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head,
    output q_stat_t q_stat
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push & ~q_stat.full;
    assign do_pop       = pop & ~q_stat.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: sv/u8vs_back.sv
module u8vs_back import u8vs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       head,
    input  q_stat_t    q_stat,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_string_end,
    output logic       m_string_clean,
    output logic       m_run_last
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       last;
    logic       take;

    assign m_valid        = ~q_stat.empty;
    assign last           = ({1'b0, idx_reg} == (head.n - 3'd1));
    assign m_out_byte     = head.data[idx_reg];
    assign m_string_end   = last & head.fin;
    assign m_string_clean = last & head.fin & head.clean;
    assign m_run_last     = last;
    assign take           = m_valid & m_ready;
    assign pop            = take & last;

    always_comb begin
        idx_next = idx_reg;
        if (take) begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule

// File: sv/utf8_validate_sanitize.sv
// channel   | direction | handshake        | payload
// ----------+-----------+------------------+--------------------------------------------------
// s_        | in        | s_valid/s_ready  | s_data_byte
// m_        | out       | m_valid/m_ready  | m_out_byte, m_string_end, m_string_clean, m_run_last
// cfg_      | in        | cfg_wr_en        | cfg_wr_data (replace_enable)
//
// the front takes one byte per cycle while the four-entry command queue has room
// a byte releases 0 to 4 results; the back sends one result per cycle while m_ready is high,
// so a byte with k results makes k output transfers and the queue absorbs bursts
// first result of a transaction can leave the cycle after the byte is taken
// aresetn is synchronous, active low: clears sequence state, queue and replace mode to 1
// either side may stall; the other keeps going until the queue fills or drains
module utf8_validate_sanitize import u8vs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_string_end,
    output logic       m_string_clean,
    output logic       m_run_last
);

    // front to queue
    logic    push;
    cmd_t    push_cmd;
    // queue to back
    cmd_t    head;
    q_stat_t q_stat;
    logic    pop;

    // front: checks each byte against the open sequence and builds a command
    u8vs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .q_stat      (q_stat),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // short queue so front and back stall independently
    u8vs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    // back: walks the result bytes of the head command, one per transaction
    u8vs_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .q_stat         (q_stat),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_string_end   (m_string_end),
        .m_string_clean (m_string_clean),
        .m_run_last     (m_run_last)
    );

`ifndef NO_ASSERTIONS
    // clean flag only rides on the end-of-string result
    a_clean_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_string_clean |-> m_string_end)
        else $error("clean flag outside end-of-string result");

    // end-of-string result is a zero byte and closes its transaction run
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_string_end |-> m_run_last && (m_out_byte == BYTE_NUL))
        else $error("malformed end-of-string result");

    // a full queue always has something to send
    a_full_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with nothing pending");

    // queued commands never carry an empty result list
    a_no_empty_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (head.n != 3'd0) && (head.n <= 3'd4))
        else $error("bad result count in queued command");
`endif

endmodule
